[rtl/bad_pkg.sv]
// Shared types, constants and the power lookup table for the apogee detector.
// No dependencies; imported by every module of the block.
package bad_pkg;

    localparam int SAMPLE_W       = 25;
    localparam int ALT_W          = 21;
    localparam int FLOOR_W        = 17;
    localparam int RATIO_W        = 17;
    localparam int PW_W           = 17;
    localparam int DIVIDEND_W     = 41;
    localparam int DIVISOR_W      = 25;
    localparam int GROUP_SIZE_DEF = 10;
    localparam int POW_TABLE_SIZE = 256;
    localparam int IDX_W          = $clog2(POW_TABLE_SIZE + 1);
    localparam logic [FLOOR_W-1:0] FLOOR_RESET = FLOOR_W'(120);
    localparam logic [RATIO_W-1:0] RATIO_MAX   = {RATIO_W{1'b1}};
    localparam logic [22:0]        ALT_SCALE   = 23'd4433000;
    localparam logic signed [ALT_W-1:0] ALT_MIN = -21'sd50000;
    localparam logic signed [ALT_W-1:0] ALT_MAX = 21'sd1000000;
    localparam longint Q30_ONE = 64'sd1073741824;
    localparam logic [63:0] LN2_Q30 = 64'd744261118;

    typedef logic [PW_W-1:0] t_pow_tab [POW_TABLE_SIZE+1];

    typedef enum logic [3:0] {
        S_IDLE, S_AVG_STORE, S_RATIO_START,
        S_RATIO_WAIT, S_INTERP_LO, S_INTERP_HI, S_ALTITUDE, S_UPDATE
    } t_state;

    typedef struct packed {
        logic accept;
        logic div_start;
        logic avg_store;
        logic ratio_store;
        logic interp_lo;
        logic interp_hi;
        logic altitude;
        logic update;
    } t_cmd;

    typedef struct packed {
        logic group_done;
        logic calibrated;
        logic div_done;
        logic out_full;
    } t_sts;

    // signed quotient truncated toward zero, by shift and subtract
    function automatic longint trunc_div(longint num, longint den);
        logic [63:0] a;
        logic [63:0] d;
        logic [63:0] q;
        logic [63:0] r;
        a = (num < 0) ? 64'(-num) : 64'(num);
        d = (den < 0) ? 64'(-den) : 64'(den);
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], a[b]};
            if (r >= d) begin
                r    = r - d;
                q[b] = 1'b1;
            end
        end
        return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
    endfunction

    // x^0.1903 in Q1.16 for x = 2i/POW_TABLE_SIZE, evaluated at elaboration
    function automatic logic [PW_W-1:0] pow_entry(int unsigned i);
        logic [63:0] v;
        logic [63:0] mag;
        logic [63:0] m;
        logic [63:0] frac;
        longint ex;
        longint lg;
        longint z;
        longint term;
        longint y;
        ex   = 0;
        frac = '0;
        if (i == 0) begin
            return '0;
        end
        v = (64'(i) << 31) / POW_TABLE_SIZE;
        for (int s = 0; s < 4; s++) begin
            if (v >= 64'h8000_0000) begin
                v  = v >> 1;
                ex = ex + 1;
            end
        end
        for (int s = 0; s < 16; s++) begin
            if (v < 64'h4000_0000) begin
                v  = v << 1;
                ex = ex - 1;
            end
        end
        for (int b = 29; b >= 0; b--) begin
            v = (v * v) >> 30;
            if (v >= 64'h8000_0000) begin
                v = v >> 1;
                frac[b] = 1'b1;
            end
        end
        lg   = ex * Q30_ONE + longint'(frac);
        mag  = (lg < 0) ? 64'(-lg) : 64'(lg);
        m    = (mag * 64'd1903) / 64'd10000;
        m    = (m * LN2_Q30) >> 30;
        z    = (lg < 0) ? -longint'(m) : longint'(m);
        term = Q30_ONE;
        y    = Q30_ONE;
        for (int n = 1; n <= 24; n++) begin
            term = trunc_div(term * z, longint'(n) * Q30_ONE);
            y    = y + term;
        end
        if (y < 0) begin
            y = 0;
        end
        m = (64'(y) + 64'd8192) >> 14;
        if (m > 64'h1FFFF) begin
            m = 64'h1FFFF;
        end
        return m[PW_W-1:0];
    endfunction

    function automatic t_pow_tab build_pow_table();
        t_pow_tab tab;
        for (int i = 0; i <= POW_TABLE_SIZE; i++) begin
            tab[i] = pow_entry(i);
        end
        return tab;
    endfunction

    localparam t_pow_tab POW_TABLE = build_pow_table();

endpackage

[rtl/barometric_apogee_detector_core.sv]
// Barometric apogee detector: top level joining sequencer and datapath.
// A sample that does not end a group leaves the sequencer idle, ready high. The sample
// ending a measured group holds ready low through mean store, ratio start, a 41-step
// bit-serial ratio division with its done strobe and four steps; the result registers
// on the last of them. A result still waiting at the output holds the update step.
// The calibration group stops at the mean store. Reset is synchronous: group state,
// calibration, peak and flag clear; floor is 120. The power table is constant logic.
module barometric_apogee_detector_core #(
    parameter int GROUP_SIZE = bad_pkg::GROUP_SIZE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_sample_valid,
    output logic                              o_sample_ready,
    input  logic [bad_pkg::SAMPLE_W-1:0]      i_pressure_sample,
    output logic                              o_result_valid,
    input  logic                              i_result_ready,
    output logic signed [bad_pkg::ALT_W-1:0]  o_altitude_cm,
    output logic signed [bad_pkg::ALT_W-1:0]  o_max_altitude_cm,
    output logic                              o_new_maximum,
    output logic                              o_descending,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bad_pkg::FLOOR_W-1:0]       i_cfg_descent_floor_cm
);
    import bad_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    bad_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .i_sts          (sts),
        .o_sample_ready (o_sample_ready),
        .o_cmd          (cmd)
    );

    bad_dp #(
        .GROUP_SIZE (GROUP_SIZE)
    ) u_dp (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cmd                  (cmd),
        .o_sts                  (sts),
        .i_pressure_sample      (i_pressure_sample),
        .i_cfg_valid            (i_cfg_valid),
        .i_cfg_descent_floor_cm (i_cfg_descent_floor_cm),
        .i_result_ready         (i_result_ready),
        .o_result_valid         (o_result_valid),
        .o_altitude_cm          (o_altitude_cm),
        .o_max_altitude_cm      (o_max_altitude_cm),
        .o_new_maximum          (o_new_maximum),
        .o_descending           (o_descending)
    );

endmodule

[rtl/bad_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on bad_pkg for operand widths.
module bad_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [bad_pkg::DIVIDEND_W-1:0]   i_dividend,
    input  logic [bad_pkg::DIVISOR_W-1:0]    i_divisor,
    output logic                             o_done,
    output logic [bad_pkg::DIVIDEND_W-1:0]   o_quotient
);
    import bad_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic [DIVISOR_W:0]    r_rem, n_rem;
    logic [DIVIDEND_W-1:0] r_quo, n_quo;
    logic [DIVISOR_W-1:0]  r_dvs;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [DIVISOR_W:0]    rem_sh;
    logic                  qbit;

    // shift in one dividend bit and trial-subtract
    always_comb begin
        rem_sh = {r_rem[DIVISOR_W-1:0], r_quo[DIVIDEND_W-1]};
        qbit   = (rem_sh >= {1'b0, r_dvs});
        n_rem  = qbit ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
        n_quo  = {r_quo[DIVIDEND_W-2:0], qbit};
    end

    // control: run for DIVIDEND_W steps, pulse done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: load operands, then iterate
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[rtl/bad_ctrl.sv]
// Sequencer for sample intake, averaging, ratio and altitude steps.
// Depends on bad_pkg for the state type and command/status structs.
module bad_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_sample_valid,
    input  bad_pkg::t_sts   i_sts,
    output logic            o_sample_ready,
    output bad_pkg::t_cmd   o_cmd
);
    import bad_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_sample_valid && i_sts.group_done) begin
                    n_state = S_AVG_STORE;
                end
            end
            S_AVG_STORE:   n_state = i_sts.calibrated ? S_RATIO_START : S_IDLE;
            S_RATIO_START: n_state = S_RATIO_WAIT;
            S_RATIO_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_INTERP_LO;
                end
            end
            S_INTERP_LO:   n_state = S_INTERP_HI;
            S_INTERP_HI:   n_state = S_ALTITUDE;
            S_ALTITUDE:    n_state = S_UPDATE;
            S_UPDATE: begin
                if (!i_sts.out_full) begin
                    n_state = S_IDLE;
                end
            end
            default:       n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd          = '0;
        o_sample_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_sample_ready = 1'b1;
                o_cmd.accept   = i_sample_valid;
            end
            S_AVG_STORE:   o_cmd.avg_store = 1'b1;
            S_RATIO_START: o_cmd.div_start = 1'b1;
            S_RATIO_WAIT:  o_cmd.ratio_store = i_sts.div_done;
            S_INTERP_LO:   o_cmd.interp_lo = 1'b1;
            S_INTERP_HI:   o_cmd.interp_hi = 1'b1;
            S_ALTITUDE:    o_cmd.altitude  = 1'b1;
            S_UPDATE:      o_cmd.update    = !i_sts.out_full;
            default:       o_cmd = '0;
        endcase
    end

endmodule

[rtl/bad_dp.sv]
// Datapath: group accumulation, divider operands, interpolation, altitude, tracking.
// Depends on bad_pkg and bad_div.
module bad_dp #(
    parameter int GROUP_SIZE = bad_pkg::GROUP_SIZE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bad_pkg::t_cmd                     i_cmd,
    output bad_pkg::t_sts                     o_sts,
    input  logic [bad_pkg::SAMPLE_W-1:0]      i_pressure_sample,
    input  logic                              i_cfg_valid,
    input  logic [bad_pkg::FLOOR_W-1:0]       i_cfg_descent_floor_cm,
    input  logic                              i_result_ready,
    output logic                              o_result_valid,
    output logic signed [bad_pkg::ALT_W-1:0]  o_altitude_cm,
    output logic signed [bad_pkg::ALT_W-1:0]  o_max_altitude_cm,
    output logic                              o_new_maximum,
    output logic                              o_descending
);
    import bad_pkg::*;

    localparam int SUM_W  = SAMPLE_W + $clog2(GROUP_SIZE);
    localparam int CNT_W  = $clog2(GROUP_SIZE);
    localparam int T_W    = RATIO_W + IDX_W;
    localparam int PROD_W = 2 * SUM_W + 1;
    // reciprocals for exact floor division of a SUM_W-bit sum by a constant
    localparam int GND_SH = SUM_W + $clog2(GROUP_SIZE);
    localparam int TRM_SH = SUM_W + $clog2(GROUP_SIZE - 2);
    localparam logic [SUM_W:0] GND_RECIP =
        (SUM_W+1)'((64'd1 << GND_SH) / 64'(GROUP_SIZE) + 64'd1);
    localparam logic [SUM_W:0] TRM_RECIP =
        (SUM_W+1)'((64'd1 << TRM_SH) / 64'(GROUP_SIZE - 2) + 64'd1);

    logic [CNT_W-1:0]       r_cnt;
    logic [SUM_W-1:0]       r_sum;
    logic [SAMPLE_W-1:0]    r_min, r_max, r_ground, r_avg;
    logic                   r_cal;
    logic [FLOOR_W-1:0]     r_floor;
    logic [IDX_W-1:0]       r_k;
    logic [RATIO_W-1:0]     r_f;
    logic [35:0]            r_prod;
    logic [PW_W:0]          r_pw;
    logic signed [ALT_W-1:0] r_alt, r_prev, r_older, r_peak;
    logic                   r_desc;
    logic                   r_o_valid, r_o_new;
    logic signed [ALT_W-1:0] r_o_alt, r_o_peak;

    logic [SUM_W-1:0]       trim_sum;
    logic [PROD_W-1:0]      gnd_prod, trm_prod;
    logic [SAMPLE_W-1:0]    gnd_mean, trm_mean;
    logic [DIVIDEND_W-1:0]  div_dividend, div_quo;
    logic [DIVISOR_W-1:0]   div_divisor;
    logic                   div_done;
    logic [RATIO_W-1:0]     ratio;
    logic [T_W-1:0]         t_scaled;
    logic [IDX_W-1:0]       k_raw;
    logic [35:0]            lo_term, hi_term;
    logic [PW_W:0]          pw_rem;
    logic [40:0]            num;
    logic signed [25:0]     alt_raw;
    logic signed [ALT_W-1:0] alt_sat;
    logic                   new_max;

    // ground mean and trimmed mean by reciprocal multiplication
    always_comb begin
        trim_sum = r_sum - SUM_W'(r_min) - SUM_W'(r_max);
        gnd_prod = PROD_W'(r_sum) * PROD_W'(GND_RECIP);
        trm_prod = PROD_W'(trim_sum) * PROD_W'(TRM_RECIP);
        gnd_mean = SAMPLE_W'(gnd_prod >> GND_SH);
        trm_mean = SAMPLE_W'(trm_prod >> TRM_SH);
    end

    // divider operands: pressure ratio to ground
    assign div_dividend = DIVIDEND_W'({r_avg, 16'b0});
    assign div_divisor  = r_ground;

    bad_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // saturate ratio and split into table index and fraction
    always_comb begin
        ratio    = (|div_quo[DIVIDEND_W-1:RATIO_W]) ? RATIO_MAX : div_quo[RATIO_W-1:0];
        t_scaled = T_W'(ratio) * T_W'(POW_TABLE_SIZE);
        k_raw    = t_scaled[T_W-1:RATIO_W];
        if (k_raw >= IDX_W'(POW_TABLE_SIZE)) begin
            k_raw = IDX_W'(POW_TABLE_SIZE - 1);
        end
    end

    // interpolation terms and altitude
    always_comb begin
        lo_term = 36'(POW_TABLE[r_k]) * 36'({1'b1, {RATIO_W{1'b0}}} - {1'b0, r_f});
        hi_term = 36'(POW_TABLE[r_k + 1'b1]) * 36'(r_f);
        pw_rem  = {1'b1, {PW_W{1'b0}}} - r_pw;
        num     = 41'(ALT_SCALE) * 41'(pw_rem);
        alt_raw = $signed(26'((num + 41'd32768) >> 16)) - $signed(26'(ALT_SCALE));
        if (alt_raw < 26'(ALT_MIN)) begin
            alt_sat = ALT_MIN;
        end else if (alt_raw > 26'(ALT_MAX)) begin
            alt_sat = ALT_MAX;
        end else begin
            alt_sat = alt_raw[ALT_W-1:0];
        end
        new_max = (r_alt > r_peak);
    end

    // control state: group counters, calibration, tracking, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_sum     <= '0;
            r_min     <= '1;
            r_max     <= '0;
            r_ground  <= '0;
            r_cal     <= 1'b0;
            r_floor   <= FLOOR_RESET;
            r_prev    <= '0;
            r_older   <= '0;
            r_peak    <= '0;
            r_desc    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_floor <= i_cfg_descent_floor_cm;
            end
            if (i_cmd.accept) begin
                r_sum <= r_sum + SUM_W'(i_pressure_sample);
                r_cnt <= r_cnt + 1'b1;
                if (i_pressure_sample < r_min) begin
                    r_min <= i_pressure_sample;
                end
                if (i_pressure_sample > r_max) begin
                    r_max <= i_pressure_sample;
                end
            end
            if (i_cmd.avg_store) begin
                if (!r_cal) begin
                    r_ground <= gnd_mean;
                    r_cal    <= 1'b1;
                end
                r_cnt <= '0;
                r_sum <= '0;
                r_min <= '1;
                r_max <= '0;
            end
            if (i_result_ready) begin
                r_o_valid <= 1'b0;
            end
            if (i_cmd.update) begin
                r_o_valid <= 1'b1;
                if (new_max) begin
                    r_peak <= r_alt;
                end
                if (r_alt < r_prev && r_alt < r_older &&
                    r_alt > $signed({{(ALT_W-FLOOR_W){1'b0}}, r_floor})) begin
                    r_desc <= 1'b1;
                end
                r_older <= r_prev;
                r_prev  <= r_alt;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.avg_store) begin
            r_avg <= trm_mean;
        end
        if (i_cmd.ratio_store) begin
            r_k <= k_raw;
            r_f <= t_scaled[RATIO_W-1:0];
        end
        if (i_cmd.interp_lo) begin
            r_prod <= lo_term;
        end
        if (i_cmd.interp_hi) begin
            r_pw <= (PW_W+1)'((r_prod + hi_term) >> RATIO_W);
        end
        if (i_cmd.altitude) begin
            r_alt <= alt_sat;
        end
        if (i_cmd.update) begin
            r_o_alt  <= r_alt;
            r_o_peak <= new_max ? r_alt : r_peak;
            r_o_new  <= new_max;
        end
    end

    assign o_sts.group_done = (r_cnt == CNT_W'(GROUP_SIZE - 1));
    assign o_sts.calibrated = r_cal;
    assign o_sts.div_done   = div_done;
    assign o_sts.out_full   = r_o_valid & ~i_result_ready;

    assign o_result_valid    = r_o_valid;
    assign o_altitude_cm     = r_o_alt;
    assign o_max_altitude_cm = r_o_peak;
    assign o_new_maximum     = r_o_new;
    assign o_descending      = r_desc;

endmodule

[dv/barometric_apogee_detector_core_tb.sv]
// Self-checking testbench for barometric_apogee_detector_core: pressure groups in,
// altitude reports out, each checked against a fixed-point predictor or a typed expectation.
// Depends on bad_pkg (widths, table size, group size) and the core RTL only.
module barometric_apogee_detector_core_tb;
    import bad_pkg::*;

    localparam int  GRP        = GROUP_SIZE_DEF;
    localparam int  CYCLE_CAP  = 600000;
    localparam int  DRAIN_WAIT = 150;
    localparam int  GROUND_P   = 25939200;
    localparam longint Q30     = 64'sd1073741824;
    localparam logic [SAMPLE_W-1:0] P_TOP = {SAMPLE_W{1'b1}};

    typedef struct packed {
        logic signed [ALT_W-1:0] alt;
        logic signed [ALT_W-1:0] peak;
        logic                    raised;
        logic                    desc;
    } t_report;

    // one directed sample; a group-ending row may carry a typed expectation
    typedef struct {
        int unsigned sample;
        bit          typed;
        t_report     report;
    } t_stim_row;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_sample_valid;
    logic                    o_sample_ready;
    logic [SAMPLE_W-1:0]     i_pressure_sample;
    logic                    o_result_valid;
    logic                    i_result_ready;
    logic signed [ALT_W-1:0] o_altitude_cm;
    logic signed [ALT_W-1:0] o_max_altitude_cm;
    logic                    o_new_maximum;
    logic                    o_descending;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [FLOOR_W-1:0]      i_cfg_descent_floor_cm;

    barometric_apogee_detector_core i_dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_sample_valid         (i_sample_valid),
        .o_sample_ready         (o_sample_ready),
        .i_pressure_sample      (i_pressure_sample),
        .o_result_valid         (o_result_valid),
        .i_result_ready         (i_result_ready),
        .o_altitude_cm          (o_altitude_cm),
        .o_max_altitude_cm      (o_max_altitude_cm),
        .o_new_maximum          (o_new_maximum),
        .o_descending           (o_descending),
        .i_cfg_valid            (i_cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_cfg_descent_floor_cm (i_cfg_descent_floor_cm)
    );

    // predictor state
    longint unsigned   pow_lut [POW_TABLE_SIZE+1];
    int unsigned       floor_cm;
    int unsigned       n_in_group;
    int unsigned       sum_acc;
    int unsigned       lo_acc;
    int unsigned       hi_acc;
    int unsigned       ground_p;
    bit                have_ground;
    longint            last_alt;
    longint            prior_alt;
    longint            peak_alt;
    bit                desc_seen;

    t_report           pending_reports[$];
    int                errors;
    int                reports_seen;
    int                samples_sent;
    int                cycles;
    bit                idling_on;

    // x^0.1903 in Q1.16 at x = 2i/POW_TABLE_SIZE, integer log/exp series
    function automatic longint unsigned pow_point(int unsigned i);
        longint unsigned v;
        longint unsigned mag;
        longint unsigned m;
        longint unsigned fr;
        longint          ex;
        longint          lg;
        longint          z;
        longint          term;
        longint          y;
        ex = 0;
        fr = 0;
        if (i == 0) return 0;
        v = (64'(i) << 31) / POW_TABLE_SIZE;
        while (v >= 64'h8000_0000) begin
            v = v >> 1;
            ex++;
        end
        while (v < 64'h4000_0000) begin
            v = v << 1;
            ex--;
        end
        for (int b = 29; b >= 0; b--) begin
            v = (v * v) >> 30;
            if (v >= 64'h8000_0000) begin
                v = v >> 1;
                fr[b] = 1'b1;
            end
        end
        lg   = ex * Q30 + longint'(fr);
        mag  = (lg < 0) ? 64'(-lg) : 64'(lg);
        m    = (mag * 64'd1903) / 64'd10000;
        m    = (m * 64'd744261118) >> 30;
        z    = (lg < 0) ? -longint'(m) : longint'(m);
        term = Q30;
        y    = Q30;
        for (int n = 1; n <= 24; n++) begin
            term = (term * z) / (longint'(n) * Q30);
            y    = y + term;
        end
        if (y < 0) y = 0;
        m = (64'(y) + 64'd8192) >> 14;
        if (m > 64'h1FFFF) m = 64'h1FFFF;
        return m;
    endfunction

    // ratio to ground, interpolated power, scaled and saturated altitude
    function automatic longint altitude_from(int unsigned avg);
        longint unsigned ratio;
        longint unsigned t;
        longint unsigned f;
        longint unsigned pw;
        longint unsigned num;
        longint unsigned k;
        longint          alt;
        if (ground_p == 0) begin
            ratio = 64'h1FFFF;
        end else begin
            ratio = (64'(avg) << 16) / ground_p;
            if (ratio > 64'h1FFFF) ratio = 64'h1FFFF;
        end
        t = ratio * POW_TABLE_SIZE;
        k = t >> 17;
        if (k >= POW_TABLE_SIZE) k = POW_TABLE_SIZE - 1;
        f   = t & 64'h1FFFF;
        pw  = (pow_lut[k] * (64'h20000 - f) + pow_lut[k+1] * f) >> 17;
        num = 64'd4433000 * (64'h20000 - pw);
        alt = longint'((num + 64'd32768) >> 16) - 4433000;
        if (alt < -50000) alt = -50000;
        if (alt > 1000000) alt = 1000000;
        return alt;
    endfunction

    function automatic void clear_group();
        n_in_group = 0;
        sum_acc    = 0;
        lo_acc     = P_TOP;
        hi_acc     = 0;
    endfunction

    function automatic void reset_barometer();
        for (int i = 0; i <= POW_TABLE_SIZE; i++) pow_lut[i] = pow_point(i);
        floor_cm    = 120;
        clear_group();
        ground_p    = 0;
        have_ground = 0;
        last_alt    = 0;
        prior_alt   = 0;
        peak_alt    = 0;
        desc_seen   = 0;
    endfunction

    // fold one sample into the group; returns 1 with a report on a measured group
    function automatic bit advance_barometer(int unsigned p, output t_report rep);
        int unsigned avg;
        longint      alt;
        bit          raised;
        raised = 0;
        rep    = '0;
        sum_acc += p;
        if (p < lo_acc) lo_acc = p;
        if (p > hi_acc) hi_acc = p;
        n_in_group++;
        if (n_in_group < GRP) return 0;
        if (!have_ground) begin
            ground_p    = sum_acc / GRP;
            have_ground = 1;
            clear_group();
            return 0;
        end
        avg = (sum_acc - lo_acc - hi_acc) / (GRP - 2);
        clear_group();
        alt = altitude_from(avg);
        if (alt > peak_alt) begin
            peak_alt = alt;
            raised   = 1;
        end
        if (alt < last_alt && alt < prior_alt && alt > longint'(floor_cm)) desc_seen = 1;
        prior_alt  = last_alt;
        last_alt   = alt;
        rep.alt    = alt[ALT_W-1:0];
        rep.peak   = peak_alt[ALT_W-1:0];
        rep.raised = raised;
        rep.desc   = desc_seen;
        return 1;
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: random stall bursts while idling is on
    initial begin
        i_result_ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (idling_on && $urandom_range(0, 3) == 0) begin
                i_result_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end else begin
                i_result_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    // compare each accepted report with the oldest prediction
    always @(posedge i_clk) begin
        t_report want;
        if (i_rst_n && o_result_valid && i_result_ready) begin
            reports_seen++;
            if (pending_reports.size() == 0) begin
                $error("unexpected report: altitude_cm=%0d", o_altitude_cm);
                errors++;
            end else begin
                want = pending_reports.pop_front();
                if (o_altitude_cm !== want.alt) begin
                    $error("altitude_cm: expected %0d, got %0d", want.alt, o_altitude_cm);
                    errors++;
                end
                if (o_max_altitude_cm !== want.peak) begin
                    $error("max_altitude_cm: expected %0d, got %0d", want.peak,
                           o_max_altitude_cm);
                    errors++;
                end
                if (o_new_maximum !== want.raised) begin
                    $error("new_maximum: expected %0b, got %0b", want.raised, o_new_maximum);
                    errors++;
                end
                if (o_descending !== want.desc) begin
                    $error("descending: expected %0b, got %0b", want.desc, o_descending);
                    errors++;
                end
            end
        end
    end

    // send one sample; valid stays high across back-to-back transactions
    task automatic send_sample(int unsigned p, bit typed, t_report typed_rep);
        t_report rep;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            i_sample_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_sample_valid    <= 1'b1;
        i_pressure_sample <= p[SAMPLE_W-1:0];
        do @(posedge i_clk); while (!o_sample_ready);
        samples_sent++;
        if (advance_barometer(p, rep)) pending_reports.push_back(typed ? typed_rep : rep);
    endtask

    // write the descent floor once all reports are in and the core has settled
    task automatic write_floor(int unsigned value);
        i_sample_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
        i_cfg_valid            <= 1'b1;
        i_cfg_descent_floor_cm <= value[FLOOR_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        floor_cm = value;
    endtask

    function automatic int unsigned pressure_at(real h_m);
        real r;
        r = 1.0 - h_m / 44330.0;
        if (r < 0.01) r = 0.01;
        return int'($rtoi(GROUND_P * (r ** (1.0 / 0.1903))));
    endfunction

    function automatic int unsigned clamp_p(longint v);
        if (v < 0) return 0;
        if (v > longint'(P_TOP)) return P_TOP;
        return int'(v);
    endfunction

    // one group around a target altitude, with noise and a possible extreme outlier
    task automatic send_group(real h_m);
        int unsigned base;
        int          spike;
        base  = pressure_at(h_m);
        spike = ($urandom_range(0, 2) == 0) ? $urandom_range(0, GRP - 1) : -1;
        for (int s = 0; s < GRP; s++) begin
            if (s == spike)
                send_sample($urandom_range(0, 1) ? $urandom_range(0, 255)
                                                 : P_TOP - $urandom_range(0, 255), 0, '0);
            else
                send_sample(clamp_p(longint'(base) + $urandom_range(0, 4000) - 2000), 0, '0);
        end
    endtask

    t_stim_row   directed[$];
    int unsigned floors[5];
    t_stim_row   row;

    initial begin
        i_rst_n                = 1'b0;
        i_sample_valid         = 1'b0;
        i_pressure_sample      = '0;
        i_cfg_valid            = 1'b0;
        i_cfg_descent_floor_cm = '0;
        errors                 = 0;
        reports_seen           = 0;
        samples_sent           = 0;
        cycles                 = 0;
        idling_on              = 1'b1;
        reset_barometer();

        // calibration at ground, then ground level, all-zero and all-ones groups
        for (int g = 0; g < 4; g++) begin
            for (int s = 0; s < GRP; s++) begin
                row.sample = (g == 2) ? 0 : (g == 3) ? P_TOP : GROUND_P;
                row.typed  = (g > 0) && (s == GRP - 1);
                row.report = (g == 1) ? t_report'{21'sd0, 21'sd0, 1'b0, 1'b0} :
                             (g == 2) ? t_report'{21'sd1000000, 21'sd1000000, 1'b1, 1'b0} :
                                        t_report'{-21'sd50000, 21'sd1000000, 1'b0, 1'b0};
                directed.push_back(row);
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) send_sample(directed[i].sample, directed[i].typed,
                                          directed[i].report);

        // flight profiles under several floors; last phase runs without idling
        floors = '{0, 100000, 120, $urandom_range(1, 99999), $urandom_range(1, 5000)};
        for (int ph = 0; ph < 5; ph++) begin
            int start;
            real apex;
            int n_up;
            int n_dn;
            write_floor(floors[ph]);
            if (ph == 4) idling_on = 1'b0;
            start = samples_sent;
            while (samples_sent - start < 320) begin
                if ($urandom_range(0, 9) == 0) begin
                    for (int s = 0; s < GRP; s++) send_sample($urandom & P_TOP, 0, '0);
                end else begin
                    apex = $urandom_range(20, 9000);
                    n_up = $urandom_range(3, 10);
                    n_dn = $urandom_range(3, 10);
                    for (int g = 1; g <= n_up; g++) send_group(apex * g / n_up);
                    for (int g = n_dn - 1; g >= 0; g--) send_group(apex * g / n_dn);
                end
            end
        end
        i_sample_valid <= 1'b0;

        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("Covered %0d samples and %0d altitude reports across 5 descent floors,",
                 samples_sent, reports_seen);
        $display("including zero, full-scale and outlier pressures and random stalls.");
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
